### rtl/core/asq_pkg.sv
package asq_pkg;

   // Width of a stored term
   localparam int TERM_BITS = 53;
   // Widths fixed by the channels
   localparam int START_BITS    = 50;
   localparam int OUT_TERM_BITS = 53;
   localparam int STEP_BITS     = 16;
   // Trial divisor never passes ceil(sqrt(2^TERM_BITS)), so this is enough
   localparam int DIV_BITS = TERM_BITS / 2 + 1;
   // Running square of the trial divisor
   localparam int SQ_BITS  = 2 * DIV_BITS;
   // Bit counter of the serial divider
   localparam int CNT_BITS = $clog2(TERM_BITS);
   // Terms above this bound stop the walk
   localparam int LIMIT_BITS = 64;
   localparam logic [LIMIT_BITS-1:0] TERM_LIMIT = 64'd1000000000000000;
   localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

   // Request command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_req;    // capture the request beat
      logic init_walk;   // set up the trial division
      logic div_start;   // launch one division by the trial divisor
      logic acc_step;    // fold in a divisor pair, move to next divisor
      logic fix_root;    // add an exact square root once
      logic do_start;    // load the start value and post its result
      logic do_hold;     // post the unchanged state
      logic do_advance;  // commit the next term and post its result
   } asq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_start;    // captured request is a start
      logic walking;     // an advance would do work
      logic sq_lt_n;     // trial divisor squared still below the term
      logic div_done;    // division result ready
      logic slot_free;   // output register can take a result
   } asq_stat_type;

endpackage

### rtl/core/asq_div.sv
module asq_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [asq_pkg::TERM_BITS-1:0]  dividend,
   input  logic [asq_pkg::DIV_BITS-1:0]   divisor,
   output logic                           done,
   output logic [asq_pkg::TERM_BITS-1:0]  quotient,
   output logic                           rem_zero
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [asq_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [asq_pkg::TERM_BITS-1:0] qr_ff, qr_in;
   logic [asq_pkg::DIV_BITS-1:0]  rem_ff, rem_in;
   logic [asq_pkg::DIV_BITS:0]    shifted;
   logic                          fits;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, qr_ff[asq_pkg::TERM_BITS-1]};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qr_in   = qr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = asq_pkg::CNT_BITS'(asq_pkg::TERM_BITS - 1);
         qr_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         qr_in = {qr_ff[asq_pkg::TERM_BITS-2:0], fits};
         if (fits) begin
            rem_in = asq_pkg::DIV_BITS'(shifted - {1'b0, divisor});
         end else begin
            rem_in = shifted[asq_pkg::DIV_BITS-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = qr_ff;
   assign rem_zero = (rem_ff == '0);

   // A new division never lands on one still in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

### rtl/core/asq_dpath.sv
module asq_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  asq_pkg::asq_cmd_type               cmd,
   output asq_pkg::asq_stat_type              stat,
   input  logic                               req_cmd,
   input  logic [asq_pkg::START_BITS-1:0]     req_start_value,
   input  logic                               csr_valid,
   input  logic [asq_pkg::STEP_BITS-1:0]      csr_max_length,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [asq_pkg::OUT_TERM_BITS-1:0]  rsp_term,
   output logic [asq_pkg::STEP_BITS-1:0]      rsp_steps_done,
   output logic                               rsp_finished,
   output logic                               rsp_overflow
);

   logic                               req_cmd_ff;
   logic [asq_pkg::START_BITS-1:0]     start_ff;
   logic [asq_pkg::STEP_BITS-1:0]      max_len_ff;
   logic [asq_pkg::TERM_BITS-1:0]      term_ff, term_in;
   logic [asq_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic                               halted_ff, halted_in;
   logic [asq_pkg::DIV_BITS-1:0]       d_ff, d_in;
   logic [asq_pkg::SQ_BITS-1:0]        sq_ff, sq_in;
   logic [asq_pkg::TERM_BITS-1:0]      sum_ff, sum_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [asq_pkg::OUT_TERM_BITS-1:0]  rsp_term_ff, rsp_term_in;
   logic [asq_pkg::STEP_BITS-1:0]      rsp_steps_ff, rsp_steps_in;
   logic                               rsp_fin_ff, rsp_fin_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;

   logic [asq_pkg::TERM_BITS-1:0]      quot;
   logic                               rem_zero;
   logic                               div_done;
   logic [asq_pkg::TERM_BITS-1:0]      start_term;
   logic [asq_pkg::STEP_BITS-1:0]      step_next;
   logic                               limit_now;
   logic                               limit_next;
   logic                               over;

   asq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (term_ff),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (quot),
      .rem_zero (rem_zero)
   );

   assign start_term = asq_pkg::TERM_BITS'(start_ff);
   assign step_next  = (step_ff < asq_pkg::STEP_MAX) ? step_ff + 1'b1 : step_ff;
   assign limit_now  = (max_len_ff != '0) && (step_ff >= max_len_ff);
   assign limit_next = (max_len_ff != '0) && (step_next >= max_len_ff);
   assign over       = asq_pkg::LIMIT_BITS'(sum_ff) > asq_pkg::TERM_LIMIT;

   // Status towards the controller
   assign stat.is_start  = (req_cmd_ff == asq_pkg::CMD_START);
   assign stat.walking   = !halted_ff && (term_ff != '0) && !limit_now;
   assign stat.sq_lt_n   = sq_ff < asq_pkg::SQ_BITS'(term_ff);
   assign stat.div_done  = div_done;
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   // Walk state, trial division and the output register
   always_comb begin
      term_in      = term_ff;
      step_in      = step_ff;
      halted_in    = halted_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_term_in  = rsp_term_ff;
      rsp_steps_in = rsp_steps_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (cmd.init_walk) begin
         d_in   = asq_pkg::DIV_BITS'(2);
         sq_in  = asq_pkg::SQ_BITS'(4);
         sum_in = (term_ff > asq_pkg::TERM_BITS'(1)) ? asq_pkg::TERM_BITS'(1) : '0;
      end

      // Fold in the pair d and n/d, then step to d+1 with (d+1)^2 = d^2 + 2d + 1
      if (cmd.acc_step) begin
         if (rem_zero) begin
            sum_in = sum_ff + asq_pkg::TERM_BITS'(d_ff) + quot;
         end
         d_in  = d_ff + 1'b1;
         sq_in = sq_ff + asq_pkg::SQ_BITS'({d_ff, 1'b1});
      end

      if (cmd.fix_root) begin
         if (sq_ff == asq_pkg::SQ_BITS'(term_ff)) begin
            sum_in = sum_ff + asq_pkg::TERM_BITS'(d_ff);
         end
      end

      if (cmd.do_start) begin
         term_in      = start_term;
         step_in      = '0;
         halted_in    = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_term_in  = asq_pkg::OUT_TERM_BITS'(start_term);
         rsp_steps_in = '0;
         rsp_fin_in   = (start_term == '0);
         rsp_ovf_in   = 1'b0;
      end

      if (cmd.do_hold) begin
         rsp_valid_in = 1'b1;
         rsp_term_in  = asq_pkg::OUT_TERM_BITS'(term_ff);
         rsp_steps_in = step_ff;
         rsp_fin_in   = 1'b1;
         rsp_ovf_in   = 1'b0;
      end

      if (cmd.do_advance) begin
         term_in      = sum_ff;
         step_in      = step_next;
         halted_in    = halted_ff || over;
         rsp_valid_in = 1'b1;
         rsp_term_in  = over ? asq_pkg::OUT_TERM_BITS'(sum_ff)
                             : asq_pkg::OUT_TERM_BITS'(term_ff);
         rsp_steps_in = step_next;
         rsp_fin_in   = over || (sum_ff == '0) || limit_next;
         rsp_ovf_in   = over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff      <= '0;
         step_ff      <= '0;
         halted_ff    <= 1'b1;
         max_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         term_ff      <= term_in;
         step_ff      <= step_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_len_ff <= csr_max_length;
         end
      end
      if (cmd.load_req) begin
         req_cmd_ff <= req_cmd;
         start_ff   <= req_start_value;
      end
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      sum_ff       <= sum_in;
      rsp_term_ff  <= rsp_term_in;
      rsp_steps_ff <= rsp_steps_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term       = rsp_term_ff;
   assign rsp_steps_done = rsp_steps_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // A result is posted only into a free output slot
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_start || cmd.do_hold || cmd.do_advance) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result posted over a waiting beat");

   // Overflow always ends the walk
   a_ovf_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> rsp_fin_ff)
      else $error("overflow beat without finished");

   // Trial divisors start at two and are never zero
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (d_ff >= asq_pkg::DIV_BITS'(2)))
      else $error("division by a divisor below two");

endmodule

### rtl/core/asq_ctrl.sv
module asq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  asq_pkg::asq_stat_type  stat,
   output asq_pkg::asq_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_TEST,
      ST_DIV,
      ST_FIX,
      ST_FIN_START,
      ST_FIN_HOLD,
      ST_FIN_ADV
   } state_type;

   state_type state_ff, state_in;

   // Decode commands and the next state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.is_start) begin
               state_in = ST_FIN_START;
            end else if (stat.walking) begin
               cmd.init_walk = 1'b1;
               state_in      = ST_TEST;
            end else begin
               state_in = ST_FIN_HOLD;
            end
         end
         ST_TEST: begin
            if (stat.sq_lt_n) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_FIX;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.acc_step = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_FIX: begin
            cmd.fix_root = 1'b1;
            state_in     = ST_FIN_ADV;
         end
         ST_FIN_START: begin
            if (stat.slot_free) begin
               cmd.do_start = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FIN_HOLD: begin
            if (stat.slot_free) begin
               cmd.do_hold = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_FIN_ADV: begin
            if (stat.slot_free) begin
               cmd.do_advance = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // At most one of the request load and the finish commands fires at a time
   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_start, cmd.do_hold, cmd.do_advance, cmd.load_req}))
      else $error("overlapping finish commands");

endmodule

### rtl/core/aliquot_sequence_stepper.sv
// Aliquot sequence stepper.
// Request channel (req_*): req_cmd start (load req_start_value, clear the
// step count) or advance (report the term, or the new one on overflow, and
// while walking replace it by the sum of its proper divisors). Each request
// beat yields exactly one rsp_* beat: term, steps_done, finished, overflow.
// Configuration (csr_*): csr_max_length is the walk length limit, 0 for no
// limit; csr_ready is always high, write only while the block is idle.
// Flow: start and non-walking advances go from decide straight to a finish
// state. A walking advance of term n runs trial division by each d from 2
// while d*d < n; each trial divisor passes the test state and one full run
// of the bit-serial divider. One request is worked at a time; the next is
// taken once the result sits in the output register.
// Reset: term 0, step count 0, no sequence loaded, limit 0; advances before
// a start report finished. If the receiver stalls, the response beat holds
// and one more request may be taken and worked; it then waits for the slot.
module aliquot_sequence_stepper (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic [asq_pkg::START_BITS-1:0]     req_start_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [asq_pkg::OUT_TERM_BITS-1:0]  rsp_term,
   output logic [asq_pkg::STEP_BITS-1:0]      rsp_steps_done,
   output logic                               rsp_finished,
   output logic                               rsp_overflow,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [asq_pkg::STEP_BITS-1:0]      csr_max_length
);

   asq_pkg::asq_cmd_type  cmd;
   asq_pkg::asq_stat_type stat;

   assign csr_ready = 1'b1;

   asq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   asq_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_start_value (req_start_value),
      .csr_valid       (csr_valid),
      .csr_max_length  (csr_max_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_term        (rsp_term),
      .rsp_steps_done  (rsp_steps_done),
      .rsp_finished    (rsp_finished),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
